@@ rtl/bla_pkg.sv @@
// ============================================================================
// bla_pkg
// Shared widths, constants, item types and the CORDIC angle table of the
// launch angle solver.
// ============================================================================
package bla_pkg;

  localparam int COORD_BITS      = 16;
  localparam int SPEED_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int GRAV_BITS       = 16;
  localparam int ANGLE_BITS      = 8 + ANGLE_FRAC_BITS;
  localparam int PRE_SHIFT       = 8;

  localparam logic [GRAV_BITS-1:0] GRAV_RESET = GRAV_BITS'(1000);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_GRAVITY = '0;

  // Product and radicand widths
  localparam int V2_W  = 2 * SPEED_BITS;
  localparam int GX_W  = GRAV_BITS + COORD_BITS;
  localparam int P_W   = 2 * V2_W;
  localparam int M_W   = 2 * GX_W;
  localparam int T_W   = GX_W + V2_W + 1;
  localparam int MAX_W = (P_W > M_W) ? ((P_W > T_W) ? P_W : T_W)
                                     : ((M_W > T_W) ? M_W : T_W);
  localparam int RAD_W = MAX_W + 2;

  // Square root
  localparam int SQ_IN_W = RAD_W + 2 * PRE_SHIFT;
  localparam int SQ_W    = (SQ_IN_W + 1) / 2;
  localparam int REM_W   = SQ_W + 3;

  // CORDIC
  localparam int NUM_W         = ((V2_W + PRE_SHIFT > SQ_W) ? V2_W + PRE_SHIFT : SQ_W) + 1;
  localparam int NORM_TOP      = 57;
  localparam int CW            = NORM_TOP + 3;
  localparam int Z_W           = 49;
  localparam int CORDIC_STEPS  = 32;
  localparam int CR_DEPTH      = CORDIC_STEPS + 3;
  localparam logic [63:0] RAD_UNITS = 64'd57295779513082;

  // Scaling to degrees: divide by 1e12 = 2^12 * 5^12
  localparam int DIV_SHIFT = 12;
  localparam logic [63:0] DIV_ODD    = 64'd244140625;
  localparam logic [63:0] ROUND_HALF = 64'd500000000000;
  localparam int NS_W = Z_W - 1 + ANGLE_FRAC_BITS + 1;
  localparam int DV_W = NS_W - DIV_SHIFT;
  localparam int Q_W  = ANGLE_BITS - 1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_REACH = 2'd1,
    ST_DIV0  = 2'd2
  } status_t;

  typedef struct packed {
    logic             valid;
    logic             func;
    logic             xneg;
    status_t          status;
    logic [V2_W-1:0]  v2;
    logic [GX_W-1:0]  gx;
    logic [RAD_W-1:0] rad;
  } sq_item_t;

  typedef struct packed {
    logic              valid;
    logic              func;
    logic              xneg;
    status_t           status;
    logic [V2_W-1:0]   v2;
    logic [GX_W-1:0]   gx;
    logic [2*SQ_W-1:0] rbits;
    logic [REM_W-1:0]  rem;
    logic [SQ_W-1:0]   root;
  } sq_stage_t;

  typedef struct packed {
    logic            valid;
    logic            func;
    logic            xneg;
    status_t         status;
    logic [V2_W-1:0] v2;
    logic [GX_W-1:0] gx;
    logic [SQ_W-1:0] root;
  } cd_item_t;

  typedef struct packed {
    logic                  valid;
    logic                  xneg;
    status_t               status;
    logic [CW-1:0]         x;
    logic [CW-1:0]         y;
    logic                  yneg;
    logic signed [Z_W-1:0] z;
  } cr_stage_t;

  typedef struct packed {
    logic                  valid;
    logic                  xneg;
    status_t               status;
    logic signed [Z_W-1:0] z;
  } dv_item_t;

  typedef struct packed {
    logic            valid;
    logic            xneg;
    status_t         status;
    logic [DV_W-1:0] rem;
    logic [Q_W-1:0]  q;
  } dv_stage_t;

  // atan(2^-i) in units of 1e-12 degree.
  function automatic logic [Z_W-2:0] atan_step(input int i);
    logic [Z_W-2:0] s;
    case (i)
      0:       s = 48'd45000000000000;
      1:       s = 48'd26565051177078;
      2:       s = 48'd14036243467926;
      3:       s = 48'd7125016348902;
      4:       s = 48'd3576334374997;
      5:       s = 48'd1789910608246;
      6:       s = 48'd895173710211;
      7:       s = 48'd447614170861;
      8:       s = 48'd223810500369;
      9:       s = 48'd111905677066;
      10:      s = 48'd55952891894;
      11:      s = 48'd27976452617;
      12:      s = 48'd13988227142;
      default: s = (Z_W-1)'(RAD_UNITS >> i);
    endcase
    return s;
  endfunction

endpackage

@@ rtl/bla_in_if.sv @@
// ============================================================================
// bla_in_if
// Request channel: mode, launch speed and target coordinates.
// ============================================================================
interface bla_in_if;
  import bla_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [SPEED_BITS-1:0]        launch_speed;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;

  modport source (output valid, func, launch_speed, target_x, target_y, input ready);
  modport sink   (input valid, func, launch_speed, target_x, target_y, output ready);
endinterface

@@ rtl/bla_out_if.sv @@
// ============================================================================
// bla_out_if
// Result channel: launch angle in signed fixed-point degrees and a status.
// ============================================================================
interface bla_out_if;
  import bla_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] angle_deg;
  status_t                      status;

  modport source (output valid, angle_deg, status, input ready);
  modport sink   (input valid, angle_deg, status, output ready);
endinterface

@@ rtl/bla_front.sv @@
// ============================================================================
// bla_front
// Product stages: squares and cross products, radicand and status.
// ============================================================================
module bla_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic                                  in_func,
  input  logic [bla_pkg::SPEED_BITS-1:0]        in_speed,
  input  logic signed [bla_pkg::COORD_BITS-1:0] in_x,
  input  logic signed [bla_pkg::COORD_BITS-1:0] in_y,
  input  logic [bla_pkg::GRAV_BITS-1:0]         grav,
  output bla_pkg::sq_item_t                     out_item
);
  import bla_pkg::*;

  // Stage 0: capture and magnitudes
  logic                  s0_valid_r, s0_func_r, s0_xneg_r, s0_yneg_r;
  logic [SPEED_BITS-1:0] s0_v_r;
  logic [COORD_BITS-1:0] s0_xm_r, s0_ym_r, xm_nxt, ym_nxt;
  logic [GRAV_BITS-1:0]  s0_g_r;
  // Stage 1: first products
  logic                  s1_valid_r, s1_func_r, s1_xneg_r, s1_yneg_r;
  logic [V2_W-1:0]       s1_v2_r, v2_nxt;
  logic [GX_W-1:0]       s1_gx_r, s1_gy_r, gx_nxt, gy_nxt;
  // Stage 2: second products
  logic                  s2_valid_r, s2_func_r, s2_xneg_r, s2_yneg_r;
  logic [V2_W-1:0]       s2_v2_r;
  logic [GX_W-1:0]       s2_gx_r;
  logic [P_W-1:0]        s2_p_r, p_nxt;
  logic [M_W-1:0]        s2_m_r, m_nxt;
  logic [T_W-1:0]        s2_t_r, t_nxt;
  logic [GX_W+V2_W-1:0]  tprod;
  // Stage 3: radicand terms
  logic                  s3_valid_r, s3_func_r, s3_xneg_r;
  logic [V2_W-1:0]       s3_v2_r;
  logic [GX_W-1:0]       s3_gx_r;
  logic [RAD_W-1:0]      s3_pp_r, s3_mm_r, pp_nxt, mm_nxt;
  // Stage 4: compare, difference, status
  sq_item_t              out_r, out_nxt;

  assign xm_nxt = in_x[COORD_BITS-1] ? COORD_BITS'(-in_x) : COORD_BITS'(in_x);
  assign ym_nxt = in_y[COORD_BITS-1] ? COORD_BITS'(-in_y) : COORD_BITS'(in_y);

  assign v2_nxt = s0_v_r * s0_v_r;
  assign gx_nxt = s0_g_r * s0_xm_r;
  assign gy_nxt = s0_g_r * s0_ym_r;

  assign p_nxt = s1_v2_r * s1_v2_r;
  assign m_nxt = s1_gx_r * s1_gx_r;
  assign tprod = s1_gy_r * s1_v2_r;
  assign t_nxt = {tprod, 1'b0};

  // In target mode a negative target height adds 2*g*|y|*v^2 to the v^4 side,
  // a positive one to the subtracted side.
  assign pp_nxt = RAD_W'(s2_p_r) + ((s2_func_r && s2_yneg_r) ? RAD_W'(s2_t_r) : '0);
  assign mm_nxt = RAD_W'(s2_m_r) + ((s2_func_r && !s2_yneg_r) ? RAD_W'(s2_t_r) : '0);

  always_comb begin
    out_nxt.valid = s3_valid_r;
    out_nxt.func  = s3_func_r;
    out_nxt.xneg  = s3_xneg_r;
    out_nxt.v2    = s3_v2_r;
    out_nxt.gx    = s3_gx_r;
    out_nxt.rad   = s3_pp_r - s3_mm_r;
    if (!s3_func_r) begin
      if (s3_v2_r == '0) begin
        out_nxt.status = ST_DIV0;
      end else if (s3_pp_r < s3_mm_r) begin
        out_nxt.status = ST_REACH;
      end else begin
        out_nxt.status = ST_OK;
      end
    end else begin
      if (s3_pp_r < s3_mm_r) begin
        out_nxt.status = ST_REACH;
      end else if (s3_gx_r == '0) begin
        out_nxt.status = ST_DIV0;
      end else begin
        out_nxt.status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_r.valid <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      out_r      <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_func_r <= in_func;
      s0_v_r    <= in_speed;
      s0_xm_r   <= xm_nxt;
      s0_ym_r   <= ym_nxt;
      s0_xneg_r <= in_x[COORD_BITS-1];
      s0_yneg_r <= in_y[COORD_BITS-1];
      s0_g_r    <= grav;

      s1_func_r <= s0_func_r;
      s1_xneg_r <= s0_xneg_r;
      s1_yneg_r <= s0_yneg_r;
      s1_v2_r   <= v2_nxt;
      s1_gx_r   <= gx_nxt;
      s1_gy_r   <= gy_nxt;

      s2_func_r <= s1_func_r;
      s2_xneg_r <= s1_xneg_r;
      s2_yneg_r <= s1_yneg_r;
      s2_v2_r   <= s1_v2_r;
      s2_gx_r   <= s1_gx_r;
      s2_p_r    <= p_nxt;
      s2_m_r    <= m_nxt;
      s2_t_r    <= t_nxt;

      s3_func_r <= s2_func_r;
      s3_xneg_r <= s2_xneg_r;
      s3_v2_r   <= s2_v2_r;
      s3_gx_r   <= s2_gx_r;
      s3_pp_r   <= pp_nxt;
      s3_mm_r   <= mm_nxt;
    end
  end

  assign out_item = out_r;

endmodule

@@ rtl/bla_sqrt.sv @@
// ============================================================================
// bla_sqrt
// Pipelined digit-by-digit square root of the radicand scaled by 2^16,
// one result bit per stage.
// ============================================================================
module bla_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  bla_pkg::sq_item_t in_item,
  output bla_pkg::cd_item_t out_item
);
  import bla_pkg::*;

  sq_stage_t seed;
  sq_stage_t cur    [SQ_W];
  sq_stage_t st_nxt [SQ_W];
  sq_stage_t st_r   [SQ_W];

  always_comb begin
    seed.valid  = in_item.valid;
    seed.func   = in_item.func;
    seed.xneg   = in_item.xneg;
    seed.status = in_item.status;
    seed.v2     = in_item.v2;
    seed.gx     = in_item.gx;
    seed.rbits  = {{(2*SQ_W-RAD_W){1'b0}}, in_item.rad} << (2 * PRE_SHIFT);
    seed.rem    = '0;
    seed.root   = '0;
  end

  for (genvar j = 0; j < SQ_W; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign cur[j] = seed;
    end else begin : g_next
      assign cur[j] = st_r[j-1];
    end

    always_comb begin : c_step
      logic [REM_W-1:0] rem2;
      logic [REM_W-1:0] trial;
      st_nxt[j]       = cur[j];
      rem2            = {cur[j].rem[REM_W-3:0], cur[j].rbits[2*SQ_W-1 -: 2]};
      trial           = {{(REM_W-SQ_W-2){1'b0}}, cur[j].root, 2'b01};
      st_nxt[j].rbits = cur[j].rbits << 2;
      if (rem2 >= trial) begin
        st_nxt[j].rem  = rem2 - trial;
        st_nxt[j].root = {cur[j].root[SQ_W-2:0], 1'b1};
      end else begin
        st_nxt[j].rem  = rem2;
        st_nxt[j].root = {cur[j].root[SQ_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[j].valid <= 1'b0;
      end else if (en) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  always_comb begin
    out_item.valid  = st_r[SQ_W-1].valid;
    out_item.func   = st_r[SQ_W-1].func;
    out_item.xneg   = st_r[SQ_W-1].xneg;
    out_item.status = st_r[SQ_W-1].status;
    out_item.v2     = st_r[SQ_W-1].v2;
    out_item.gx     = st_r[SQ_W-1].gx;
    out_item.root   = st_r[SQ_W-1].root;
  end

endmodule

@@ rtl/bla_cordic.sv @@
// ============================================================================
// bla_cordic
// Builds the atan operands, normalizes them in two shift stages, then runs
// a vectoring CORDIC with one rotation per stage.
// ============================================================================
module bla_cordic (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  bla_pkg::cd_item_t in_item,
  output bla_pkg::dv_item_t out_item
);
  import bla_pkg::*;

  cr_stage_t cur    [CR_DEPTH];
  cr_stage_t st_nxt [CR_DEPTH];
  cr_stage_t st_r   [CR_DEPTH];

  for (genvar j = 0; j < CR_DEPTH; j++) begin : g_stage
    if (j == 0) begin : g_prep
      assign cur[j] = st_r[CR_DEPTH-1];
      always_comb begin : c_prep
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] gx8;
        num              = NUM_W'({in_item.v2, {PRE_SHIFT{1'b0}}}) + NUM_W'(in_item.root);
        gx8              = NUM_W'({in_item.gx, {PRE_SHIFT{1'b0}}});
        st_nxt[j].valid  = in_item.valid;
        st_nxt[j].xneg   = in_item.xneg;
        st_nxt[j].status = in_item.status;
        st_nxt[j].x      = CW'(in_item.func ? gx8 : num);
        st_nxt[j].y      = CW'(in_item.func ? num : gx8);
        st_nxt[j].yneg   = 1'b0;
        st_nxt[j].z      = '0;
      end
    end else if (j < 3) begin : g_norm
      // Shift left until the larger operand reaches 2^57.
      localparam int BASE = (j == 1) ? 32 : 4;
      assign cur[j] = st_r[j-1];
      always_comb begin : c_norm
        logic [CW-1:0] o;
        int k;
        st_nxt[j] = cur[j];
        for (int s = 0; s < 3; s++) begin
          k = BASE >> s;
          o = st_nxt[j].x | st_nxt[j].y;
          if (o != '0 && (o >> (NORM_TOP + 1 - k)) == '0) begin
            st_nxt[j].x = st_nxt[j].x << k;
            st_nxt[j].y = st_nxt[j].y << k;
          end
        end
      end
    end else begin : g_rot
      localparam int I = j - 3;
      assign cur[j] = st_r[j-1];
      always_comb begin : c_rot
        logic [CW-1:0] xs;
        logic [CW-1:0] ys;
        logic signed [Z_W-1:0] stp;
        st_nxt[j] = cur[j];
        xs        = cur[j].x >> I;
        ys        = cur[j].y >> I;
        stp       = $signed({1'b0, atan_step(I)});
        st_nxt[j].z = cur[j].yneg ? (cur[j].z - stp) : (cur[j].z + stp);
        st_nxt[j].x = cur[j].x + ys;
        if (cur[j].y >= xs) begin
          st_nxt[j].y = cur[j].y - xs;
        end else begin
          st_nxt[j].y    = xs - cur[j].y;
          st_nxt[j].yneg = !cur[j].yneg;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[j].valid <= 1'b0;
      end else if (en) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  always_comb begin
    out_item.valid  = st_r[CR_DEPTH-1].valid;
    out_item.xneg   = st_r[CR_DEPTH-1].xneg;
    out_item.status = st_r[CR_DEPTH-1].status;
    out_item.z      = st_r[CR_DEPTH-1].z;
  end

endmodule

@@ rtl/bla_scale.sv @@
// ============================================================================
// bla_scale
// Converts the CORDIC angle sum to rounded fixed-point degrees with a
// one-bit-per-stage division by the odd part of 10^12, applies the sign and
// holds the result register.
// ============================================================================
module bla_scale (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  bla_pkg::dv_item_t                     in_item,
  output logic                                  out_valid,
  output logic signed [bla_pkg::ANGLE_BITS-1:0] out_angle,
  output bla_pkg::status_t                      out_status
);
  import bla_pkg::*;

  dv_stage_t cur    [Q_W+1];
  dv_stage_t st_nxt [Q_W+1];
  dv_stage_t st_r   [Q_W+1];

  logic                         valid_r;
  logic signed [ANGLE_BITS-1:0] angle_r, angle_nxt;
  status_t                      status_r;

  for (genvar j = 0; j <= Q_W; j++) begin : g_stage
    if (j == 0) begin : g_prep
      assign cur[j] = st_r[Q_W];
      always_comb begin : c_prep
        logic [NS_W-1:0] zc;
        logic [NS_W-1:0] n;
        zc = in_item.z[Z_W-1] ? '0 : NS_W'(in_item.z[Z_W-2:0]);
        n  = (zc << ANGLE_FRAC_BITS) + NS_W'(ROUND_HALF);
        st_nxt[j].valid  = in_item.valid;
        st_nxt[j].xneg   = in_item.xneg;
        st_nxt[j].status = in_item.status;
        st_nxt[j].rem    = n[NS_W-1:DIV_SHIFT];
        st_nxt[j].q      = '0;
      end
    end else begin : g_div
      localparam int B = Q_W - j;
      assign cur[j] = st_r[j-1];
      always_comb begin : c_div
        logic [DV_W-1:0] dsh;
        st_nxt[j] = cur[j];
        dsh       = DV_W'(DIV_ODD) << B;
        if (cur[j].rem >= dsh) begin
          st_nxt[j].rem  = cur[j].rem - dsh;
          st_nxt[j].q[B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[j].valid <= 1'b0;
      end else if (en) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  always_comb begin
    if (st_r[Q_W].status != ST_OK) begin
      angle_nxt = '0;
    end else if (st_r[Q_W].xneg) begin
      angle_nxt = -$signed({1'b0, st_r[Q_W].q});
    end else begin
      angle_nxt = $signed({1'b0, st_r[Q_W].q});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= st_r[Q_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r  <= angle_nxt;
      status_r <= st_r[Q_W].status;
    end
  end

  assign out_valid  = valid_r;
  assign out_angle  = angle_r;
  assign out_status = status_r;

endmodule

@@ rtl/ballistic_launch_angle.sv @@
// ============================================================================
// ballistic_launch_angle
// Launch angle solver: angle of reach for a level range, or high-arc angle
// to a target point, in signed fixed-point degrees.
// ============================================================================
// Usage. Requests arrive on in_ch (mode, speed, target x and y) and results
// leave on out_ch (angle_deg in signed Q8.8 degrees and a status code). A
// transfer happens on either channel at a rising edge with valid and ready
// both high. Gravity sits in register 0 of the APB-style port and should be
// written only while no request is in flight; it resets to 1000.
// Throughput is one request per cycle unless the receiver stalls with a
// result waiting. A request passes 99 register stages: 5 product stages,
// 42 square-root stages (one root bit each), 35 CORDIC stages (operand
// setup, two normalize stages, 32 rotations) and 17 scaling stages
// including the output register. An input transfer loads the first stage.
// The whole pipeline moves on one enable. When the receiver stalls with a
// result waiting, every stage holds, in_ch.ready drops, and nothing is lost
// or repeated; bubbles still advance whenever the output register is empty.
// Reset (synchronous, active low) clears every stage valid bit and restores
// the gravity register.
// ============================================================================
module ballistic_launch_angle (
  input  logic                          clk,
  input  logic                          rst_n,
  bla_in_if.sink                        in_ch,
  bla_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bla_pkg::PADDR_W-1:0]   paddr,
  input  logic [bla_pkg::PDATA_W-1:0]   pwdata,
  output logic [bla_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import bla_pkg::*;

  logic [GRAV_BITS-1:0] grav_r;
  logic                 en;
  logic                 out_valid;
  sq_item_t             sq_item;
  cd_item_t             cd_item;
  dv_item_t             dv_item;

  // Register access. The port never waits.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= GRAV_RESET;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_GRAVITY) begin
      grav_r <= pwdata[GRAV_BITS-1:0];
    end
  end

  always_comb begin
    if (paddr[PADDR_W-1:2] == REG_GRAVITY) begin
      prdata = PDATA_W'(grav_r);
    end else begin
      prdata = '0;
    end
  end

  // The pipeline advances whenever the output register is free or its
  // contents are being transferred out this cycle.
  assign en          = !out_valid || out_ch.ready;
  assign in_ch.ready = en;

  bla_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_speed (in_ch.launch_speed),
    .in_x     (in_ch.target_x),
    .in_y     (in_ch.target_y),
    .grav     (grav_r),
    .out_item (sq_item)
  );

  bla_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_item  (sq_item),
    .out_item (cd_item)
  );

  bla_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_item  (cd_item),
    .out_item (dv_item)
  );

  bla_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_item    (dv_item),
    .out_valid  (out_valid),
    .out_angle  (out_ch.angle_deg),
    .out_status (out_ch.status)
  );

  assign out_ch.valid = out_valid;

  // A failed solve always reports a zero angle.
  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.angle_deg == '0)
    else $error("nonzero angle with error status");

  // The gravity register changes only through a register write.
  a_grav_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !(psel && penable && pwrite) |=> $stable(grav_r))
    else $error("gravity changed without a write");

  // Reset empties the pipeline output.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result presented right after reset");

  // While the pipeline is frozen, the product and CORDIC stage outputs hold.
  a_stall_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dv_item) && $stable(sq_item))
    else $error("pipeline moved during a stall");

endmodule

@@ tb/tb_ballistic_launch_angle.sv @@
// ----------------------------------------------------------------------------
// Launch angle solver testbench
// Drives solve requests through the request channel in random bursts, stalls
// the result channel on its own pattern, and checks every result against an
// in-bench fixed-point model of the reach and high-arc angle solutions.
// ----------------------------------------------------------------------------
module tb_ballistic_launch_angle;
  import bla_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Latency of the pipeline plus some margin, used before gravity writes
  // and at the end of the run.
  localparam int DRAIN_CYCLES = 130;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic                         func;
    logic [SPEED_BITS-1:0]        speed;
    logic signed [COORD_BITS-1:0] tx;
    logic signed [COORD_BITS-1:0] ty;
  } solve_req_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle;
    status_t               status;
  } solve_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bla_in_if  req_ch();
  bla_out_if res_ch();

  ballistic_launch_angle u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch.sink), .out_ch(res_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gravity as the solver currently sees it.
  logic [15:0] gravity = 16'd1000;

  solve_req_t pending_reqs[$];
  solve_res_t expected_angles[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  // CORDIC step angles in units of 1e-12 degree.
  function automatic logic [63:0] step_angle(input int i);
    logic [63:0] tbl [13];
    tbl = '{64'd45000000000000, 64'd26565051177078, 64'd14036243467926,
            64'd7125016348902, 64'd3576334374997, 64'd1789910608246,
            64'd895173710211, 64'd447614170861, 64'd223810500369,
            64'd111905677066, 64'd55952891894, 64'd27976452617,
            64'd13988227142};
    if (i < 13) return tbl[i];
    return 64'd57295779513082 >> i;
  endfunction

  // Exact floor square root of a 128-bit value.
  function automatic logic [63:0] floor_sqrt(input logic [127:0] d);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= d) r = t;
    end
    return r;
  endfunction

  // Vectoring CORDIC: angle of the vector (run, rise) in 1e-12 degree units.
  function automatic logic [63:0] cordic_angle(input logic [63:0] rise,
                                                input logic [63:0] run);
    logic [63:0] x, y, z, xs, ys, stp;
    bit yneg;
    x = run; y = rise; z = '0; yneg = 1'b0;
    for (int i = 0; i < 64 && (x | y) != 0 && (x | y) < (64'd1 << 57); i++) begin
      x = x << 1;
      y = y << 1;
    end
    for (int i = 0; i < 32; i++) begin
      stp = step_angle(i);
      xs = x >> i;
      ys = y >> i;
      z = yneg ? z - stp : z + stp;
      x = x + ys;
      if (y >= xs) y = y - xs;
      else begin
        y = xs - y;
        yneg = !yneg;
      end
    end
    if (z[63]) z = '0;
    return z;
  endfunction

  function automatic solve_res_t predict_angle(input solve_req_t r,
                                               input logic [15:0] g);
    solve_res_t res;
    logic [15:0] xm, ym;
    logic [63:0] v2, gx, rise, run, z, q;
    logic [127:0] pp, mm, tt;
    bit xneg;
    xneg = r.tx[15];
    xm = xneg ? 16'(-r.tx) : r.tx;
    ym = r.ty[15] ? 16'(-r.ty) : r.ty;
    v2 = 64'(r.speed) * 64'(r.speed);
    gx = 64'(g) * 64'(xm);
    pp = {64'd0, v2} * {64'd0, v2};
    mm = {64'd0, gx} * {64'd0, gx};
    res.status = ST_OK;
    if (r.func == 1'b0) begin
      if (r.speed == 0) res.status = ST_DIV0;
      else if (pp < mm) res.status = ST_REACH;
      rise = gx << 8;
      run = (v2 << 8) + floor_sqrt((pp - mm) << 16);
    end else begin
      tt = {64'd0, 64'd2 * 64'(g) * 64'(ym)} * {64'd0, v2};
      if (r.ty[15]) pp = pp + tt;
      else mm = mm + tt;
      if (pp < mm) res.status = ST_REACH;
      else if (gx == 0) res.status = ST_DIV0;
      rise = (v2 << 8) + floor_sqrt((pp - mm) << 16);
      run = gx << 8;
    end
    if (res.status != ST_OK) begin
      res.angle = '0;
      return res;
    end
    z = cordic_angle(rise, run);
    q = ((z << ANGLE_FRAC_BITS) + 64'd500000000000) / 64'd1000000000000;
    res.angle = xneg ? ANGLE_BITS'(-q) : ANGLE_BITS'(q);
    return res;
  endfunction

  // Driver: bursts of transfers separated by random gaps. valid stays high
  // between back-to-back items, so each step assigns it once.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_angles.push_back(predict_angle(pending_reqs.pop_front(), gravity));
        idle_cycles = 0;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // Hold the current item until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_ch.valid <= 1'b1;
        req_ch.func <= pending_reqs[0].func;
        req_ch.launch_speed <= pending_reqs[0].speed;
        req_ch.target_x <= pending_reqs[0].tx;
        req_ch.target_y <= pending_reqs[0].ty;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver: stalls follow a slowly changing duty pattern.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        idle_cycles = 0;
        if (expected_angles.size() == 0) begin
          $display("%0t: result with nothing expected: angle %0d status %0d",
                   $realtime, res_ch.angle_deg, res_ch.status);
          error_count++;
        end else begin
          automatic solve_res_t exp_r = expected_angles.pop_front();
          if (exp_r.angle !== res_ch.angle_deg) begin
            $display("%0t: angle_deg mismatch: expected %0d actual %0d", $realtime,
                     $signed(exp_r.angle), res_ch.angle_deg);
            error_count++;
          end
          if (exp_r.status !== res_ch.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $realtime,
                     exp_r.status, res_ch.status);
            error_count++;
          end
        end
      end
      stall_phase = (stall_phase + 1) % 300;
      if (stall_phase < 100) res_ch.ready <= 1'b1;
      else if (stall_phase < 200) res_ch.ready <= ($urandom_range(0, 3) != 0);
      else res_ch.ready <= ($urandom_range(0, 2) == 0);
    end
  end

  // Watchdog: cycles without any transfer while work is outstanding.
  always @(posedge clk) begin
    if (rst_n && (pending_reqs.size() > 0 || expected_angles.size() > 0)) begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // APB write: setup cycle then access cycle.
  task automatic write_gravity(input logic [15:0] g);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(REG_GRAVITY) << 2; pwdata <= PDATA_W'(g);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    gravity = g;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_angles.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic solve_req_t make_req(input logic f, input logic [15:0] v,
                                          input logic [15:0] x, input logic [15:0] y);
    solve_req_t r;
    r.func = f; r.speed = v; r.tx = x; r.ty = y;
    return r;
  endfunction

  // Random request biased toward reachable targets: speeds large relative to
  // distance times gravity, with full-range noise mixed in.
  function automatic solve_req_t rand_req(input logic [15:0] g);
    solve_req_t r;
    int sel;
    sel = $urandom_range(0, 9);
    r.func = 1'($urandom_range(0, 1));
    r.speed = 16'($urandom);
    r.tx = 16'($urandom);
    r.ty = 16'($urandom);
    if (sel < 7) begin
      // Keep g*|x| on the order of v^2 so both outcomes appear.
      r.speed = 16'($urandom_range(1, 65535));
      r.tx = 16'($urandom_range(0, 32767));
      if (g > 0) r.tx = 16'((64'(r.speed) * r.speed / g) >> $urandom_range(0, 4));
      if (r.tx[15]) r.tx = 16'($urandom_range(0, 32767));
      if ($urandom_range(0, 1)) r.tx = -r.tx;
      r.ty = 16'($signed(r.tx) >>> $urandom_range(0, 6));
      if ($urandom_range(0, 1)) r.ty = -r.ty;
    end else if (sel == 7) begin
      r.tx = 16'($urandom_range(0, 3)) - 16'd1;
      r.speed = 16'($urandom_range(0, 3));
    end
    return r;
  endfunction

  initial begin
    logic [15:0] grav_set [6];
    req_ch.valid = 1'b0;
    req_ch.func = 1'b0;
    req_ch.launch_speed = '0;
    req_ch.target_x = '0;
    req_ch.target_y = '0;
    res_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset gravity: extremes of every field,
    // both modes, zero speed, zero distance, out of reach and negative x.
    pending_reqs.push_back(make_req(1'b0, 16'd0, 16'd100, 16'd0));
    pending_reqs.push_back(make_req(1'b0, 16'd65535, 16'h7fff, 16'h7fff));
    pending_reqs.push_back(make_req(1'b0, 16'd65535, 16'h8000, 16'h8000));
    pending_reqs.push_back(make_req(1'b0, 16'd100, 16'd10, 16'd0));
    pending_reqs.push_back(make_req(1'b0, 16'd100, 16'd20, 16'd0));
    pending_reqs.push_back(make_req(1'b0, 16'd100, 16'd11, 16'd0));
    pending_reqs.push_back(make_req(1'b0, 16'd100, -16'sd10, 16'd0));
    pending_reqs.push_back(make_req(1'b0, 16'd1, 16'd0, 16'd0));
    pending_reqs.push_back(make_req(1'b1, 16'd100, 16'd0, 16'd0));
    pending_reqs.push_back(make_req(1'b1, 16'd100, 16'd0, 16'd100));
    pending_reqs.push_back(make_req(1'b1, 16'd100, 16'd5, 16'd5));
    pending_reqs.push_back(make_req(1'b1, 16'd100, -16'sd5, -16'sd5));
    pending_reqs.push_back(make_req(1'b1, 16'd10, 16'd100, 16'd100));
    pending_reqs.push_back(make_req(1'b1, 16'd0, 16'd0, -16'sd1));
    pending_reqs.push_back(make_req(1'b1, 16'd0, 16'd1, 16'd0));
    pending_reqs.push_back(make_req(1'b1, 16'd65535, 16'h7fff, 16'h8000));
    pending_reqs.push_back(make_req(1'b1, 16'd65535, 16'h8000, 16'h7fff));
    pending_reqs.push_back(make_req(1'b1, 16'd65535, 16'hffff, 16'hffff));
    pending_reqs.push_back(make_req(1'b1, 16'd200, 16'd40, 16'd0));
    wait_drained();

    // Gravity settings include both extremes and the reset value.
    grav_set = '{16'd1, 16'd65535, 16'd9, 16'd1000, 16'd0, 16'd321};
    foreach (grav_set[k]) begin
      write_gravity(grav_set[k]);
      if (grav_set[k] == 0) begin
        pending_reqs.push_back(make_req(1'b0, 16'd50, 16'd7, 16'd0));
        pending_reqs.push_back(make_req(1'b1, 16'd50, 16'd7, 16'd3));
      end
      for (int n = 0; n < 280; n++) pending_reqs.push_back(rand_req(gravity));
      wait_drained();
    end
    stim_done = 1'b1;

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bla_pkg.sv
rtl/bla_in_if.sv
rtl/bla_out_if.sv
rtl/bla_front.sv
rtl/bla_sqrt.sv
rtl/bla_cordic.sv
rtl/bla_scale.sv
rtl/ballistic_launch_angle.sv
tb/tb_ballistic_launch_angle.sv
